// ===== hdl/gng_pkg.sv =====
package gng_pkg;

    // datapath width of the shared unit and fixed-point constants (Q30)
    localparam int DW = 58;
    localparam int VW = 54;
    localparam int RW = 27;
    localparam int PW = 61;

    localparam logic [30:0] ONE_Q30    = 31'd1073741824;
    localparam logic [29:0] LN2_Q30    = 30'd744261118;
    localparam logic [30:0] HALFPI_Q30 = 31'd1686629713;
    localparam logic [29:0] INVK_Q30   = 30'd652032874;

    // index of the last iteration of each of the three passes of the shared unit
    localparam logic [4:0] LN_LAST = 5'd31;
    localparam logic [4:0] SQ_LAST = 5'd26;
    localparam logic [4:0] SC_LAST = 5'd29;

    typedef enum logic [1:0] {
        MODE_CIRC,
        MODE_HYP,
        MODE_SQRT
    } mode_t;

    typedef struct packed {
        logic                 load;
        logic                 step;
        mode_t                mode;
        logic [4:0]           k;
        logic signed [DW-1:0] x0;
        logic signed [DW-1:0] y0;
        logic signed [DW-1:0] z0;
    } ctl_t;

    typedef struct packed {
        logic        valid;
        logic [15:0] sample;
        logic        spare;
    } out_t;

    // hyperbolic shift sequence with the repeats at 4 and 13
    function automatic logic [4:0] hyp_shift(input logic [4:0] k);
        if (k < 5'd4) begin
            hyp_shift = k + 5'd1;
        end else if (k < 5'd14) begin
            hyp_shift = k;
        end else begin
            hyp_shift = k - 5'd1;
        end
    endfunction

    // atan(2^-i) in Q30
    function automatic logic [30:0] atan_q30(input logic [4:0] i);
        unique case (i)
            5'd0:    atan_q30 = 31'd843314857;
            5'd1:    atan_q30 = 31'd497837830;
            5'd2:    atan_q30 = 31'd263043837;
            5'd3:    atan_q30 = 31'd133525159;
            5'd4:    atan_q30 = 31'd67021687;
            5'd5:    atan_q30 = 31'd33543515;
            5'd6:    atan_q30 = 31'd16775851;
            5'd7:    atan_q30 = 31'd8388437;
            5'd8:    atan_q30 = 31'd4194283;
            5'd9:    atan_q30 = 31'd2097149;
            5'd10:   atan_q30 = 31'd1048576;
            default: atan_q30 = 31'd1 << (5'd30 - i);
        endcase
    endfunction

    // atanh(2^-i) in Q30, i from 1
    function automatic logic [30:0] atanh_q30(input logic [4:0] i);
        unique case (i)
            5'd1:    atanh_q30 = 31'd589812981;
            5'd2:    atanh_q30 = 31'd274247419;
            5'd3:    atanh_q30 = 31'd134923406;
            5'd4:    atanh_q30 = 31'd67196451;
            5'd5:    atanh_q30 = 31'd33565361;
            5'd6:    atanh_q30 = 31'd16778582;
            5'd7:    atanh_q30 = 31'd8388779;
            5'd8:    atanh_q30 = 31'd4194325;
            5'd9:    atanh_q30 = 31'd2097155;
            5'd10:   atanh_q30 = 31'd1048576;
            default: atanh_q30 = 31'd1 << (5'd30 - i);
        endcase
    endfunction

    // radius (Q20) times trig magnitude (Q30) to rounded, saturated Q8.8
    function automatic logic [15:0] to_q88(input logic [PW-1:0] p, input logic neg);
        logic [PW-1:0] v;
        v = (p + (61'd1 << 41)) >> 42;
        if (neg) begin
            if (v > 61'd32768) begin
                v = 61'd32768;
            end
            to_q88 = ~v[15:0] + 16'd1;
        end else begin
            if (v > 61'd32767) begin
                v = 61'd32767;
            end
            to_q88 = v[15:0];
        end
    endfunction

endpackage

// ===== hdl/gaussian_noise_generator.sv =====
// Gaussian noise sample generator (Box-Muller).
// Input stream s_*: each transaction carries two uniform words. Output stream m_*:
// one signed Q8.8 sample per input transaction, tuser set when it is the stored
// sine half of a pair.
// Configuration: cfg_valid/cfg_data write the variance (unsigned Q8.8); cfg_ready
// is always high. Write it only while the block is idle.
// With no spare held, a transaction forms a pair: the exponent search shifts
// once per bit of floor(log2(uniform_a+1)) (0 to UNIFORM_BITS), then the shared
// CORDIC / square-root unit runs 32 hyperbolic steps for the logarithm, 27
// digit steps for the square root and 30 circular steps for sine and cosine,
// with the shared multiplier used between and after the passes.
// The cosine is returned, the sine is kept as spare. The next transaction then
// returns the spare in the cycle after acceptance and its words are dropped.
// s_tready is low while a pair is formed.
// Reset (aresetn low, synchronous) drops any spare and any pending result and
// sets the variance to 1.0. When m_tready is low the result holds in the output
// register; a spare can only be returned once that register is free.
module gaussian_noise_generator #(
    parameter int UNIFORM_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [15:0] uniform_a, [31:16] uniform_b
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] sample
    output logic        m_tuser,   // [0] from_spare
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    logic [15:0]                   variance_reg;
    logic                          m_valid_reg;
    logic [15:0]                   m_sample_reg;
    logic                          m_spare_reg;
    logic                          slot_free;
    gng_pkg::out_t                 out_wr;
    gng_pkg::ctl_t                 ctl;
    logic signed [gng_pkg::DW-1:0] cx, cy, cz;

    assign cfg_ready = 1'b1;
    assign slot_free = !m_valid_reg || m_tready;

    // variance register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            variance_reg <= 16'd256;
        end else if (cfg_valid && cfg_ready) begin
            variance_reg <= cfg_data;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_wr.valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_wr.valid) begin
            m_sample_reg <= out_wr.sample;
            m_spare_reg  <= out_wr.spare;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_sample_reg;
    assign m_tuser  = m_spare_reg;

    gng_seq #(
        .UNIFORM_BITS (UNIFORM_BITS)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .uniform_a (s_tdata[15:0]),
        .uniform_b (s_tdata[31:16]),
        .variance  (variance_reg),
        .slot_free (slot_free),
        .out_wr    (out_wr),
        .ctl       (ctl),
        .x_i       (cx),
        .y_i       (cy),
        .z_i       (cz)
    );

    gng_cordic u_cordic (
        .aclk (aclk),
        .ctl  (ctl),
        .x_o  (cx),
        .y_o  (cy),
        .z_o  (cz)
    );

endmodule

// ===== hdl/gng_cordic.sv =====
module gng_cordic (
    input  logic                              aclk,
    input  gng_pkg::ctl_t                     ctl,
    output logic signed [gng_pkg::DW-1:0]     x_o,
    output logic signed [gng_pkg::DW-1:0]     y_o,
    output logic signed [gng_pkg::DW-1:0]     z_o
);

    logic signed [gng_pkg::DW-1:0] x_reg, y_reg, z_reg;
    logic signed [gng_pkg::DW-1:0] x_next, y_next, z_next;
    logic signed [gng_pkg::DW-1:0] xs, ys, tab;
    logic [gng_pkg::DW-1:0]        rem, trial;
    logic [4:0]                    sh;
    logic                          dpos;

    // shift amount, angle table entry and direction of the micro-rotation; square-root remainder and trial
    always_comb begin
        sh   = ctl.k;
        tab  = '0;
        dpos = 1'b0;
        unique case (ctl.mode)
            gng_pkg::MODE_CIRC: begin
                sh   = ctl.k;
                tab  = gng_pkg::DW'(gng_pkg::atan_q30(ctl.k));
                dpos = ~z_reg[gng_pkg::DW-1];
            end
            gng_pkg::MODE_HYP: begin
                sh   = gng_pkg::hyp_shift(ctl.k);
                tab  = gng_pkg::DW'(gng_pkg::atanh_q30(gng_pkg::hyp_shift(ctl.k)));
                dpos = y_reg[gng_pkg::DW-1];
            end
            default: begin
                sh   = ctl.k;
                tab  = '0;
                dpos = 1'b0;
            end
        endcase
        xs    = x_reg >>> sh;
        ys    = y_reg >>> sh;
        rem   = {x_reg[gng_pkg::DW-3:0], z_reg[gng_pkg::VW-1 -: 2]};
        trial = {y_reg[gng_pkg::DW-3:0], 2'b01};
    end

    // load or one step of the shared unit
    always_comb begin
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        if (ctl.load) begin
            x_next = ctl.x0;
            y_next = ctl.y0;
            z_next = ctl.z0;
        end else if (ctl.step) begin
            unique case (ctl.mode)
                gng_pkg::MODE_CIRC: begin
                    x_next = dpos ? x_reg - ys : x_reg + ys;
                    y_next = dpos ? y_reg + xs : y_reg - xs;
                    z_next = dpos ? z_reg - tab : z_reg + tab;
                end
                gng_pkg::MODE_HYP: begin
                    x_next = dpos ? x_reg + ys : x_reg - ys;
                    y_next = dpos ? y_reg + xs : y_reg - xs;
                    z_next = dpos ? z_reg - tab : z_reg + tab;
                end
                default: begin
                    if (rem >= trial) begin
                        x_next = $signed(rem - trial);
                        y_next = {y_reg[gng_pkg::DW-2:0], 1'b1};
                    end else begin
                        x_next = $signed(rem);
                        y_next = {y_reg[gng_pkg::DW-2:0], 1'b0};
                    end
                    z_next = z_reg <<< 2;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    assign x_o = x_reg;
    assign y_o = y_reg;
    assign z_o = z_reg;

endmodule

// ===== hdl/gng_seq.sv =====
module gng_seq #(
    parameter int UNIFORM_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [15:0]                   uniform_a,
    input  logic [15:0]                   uniform_b,
    input  logic [15:0]                   variance,
    input  logic                          slot_free,
    output gng_pkg::out_t                 out_wr,
    output gng_pkg::ctl_t                 ctl,
    input  logic signed [gng_pkg::DW-1:0] x_i,
    input  logic signed [gng_pkg::DW-1:0] y_i,
    input  logic signed [gng_pkg::DW-1:0] z_i
);

    localparam logic [32:0] MASK_W = (33'd1 << UNIFORM_BITS) - 33'd1;
    localparam logic [39:0] FULL_LN = 40'(UNIFORM_BITS) * 40'(gng_pkg::LN2_Q30);
    localparam logic [5:0]  PH_SH = 6'(32 - UNIFORM_BITS);

    typedef enum logic [13:0] {
        ST_IDLE    = 14'b00000000000001,
        ST_NORM    = 14'b00000000000010,
        ST_LN_RUN  = 14'b00000000000100,
        ST_LN_END  = 14'b00000000001000,
        ST_V_MUL   = 14'b00000000010000,
        ST_SQ_LOAD = 14'b00000000100000,
        ST_SQ_RUN  = 14'b00000001000000,
        ST_SQ_END  = 14'b00000010000000,
        ST_SC_LOAD = 14'b00000100000000,
        ST_SC_RUN  = 14'b00001000000000,
        ST_SC_END  = 14'b00010000000000,
        ST_C_MUL   = 14'b00100000000000,
        ST_S_MUL   = 14'b01000000000000,
        ST_DONE    = 14'b10000000000000
    } state_t;

    state_t                  state_reg, state_next;
    logic [4:0]              k_reg, k_next;
    logic                    spare_valid_reg, spare_valid_next;
    logic [15:0]             spare_reg, spare_next;
    logic [62:0]             m_reg, m_next;
    logic [5:0]              e_reg, e_next;
    logic [31:0]             ph_reg, ph_next;
    logic [35:0]             l2_reg, l2_next;
    logic [gng_pkg::PW-1:0]  prod_reg;
    logic [gng_pkg::RW-1:0]  r_reg, r_next;
    logic signed [32:0]      cs_reg, cs_next, sn_reg, sn_next;
    logic [15:0]             cos_reg, cos_next;

    logic [35:0]             mul_a;
    logic [30:0]             mul_b;
    logic [66:0]             mul_full;
    logic                    in_accept;
    logic [32:0]             xa;
    logic signed [39:0]      lnx, negl;
    logic signed [32:0]      c_q, s_q;
    logic [32:0]             cs_abs, sn_abs;

    assign in_accept = in_valid && in_ready;
    assign in_ready  = (state_reg == ST_IDLE) && slot_free;
    assign xa        = ({17'd0, uniform_a} & MASK_W) + 33'd1;

    // -ln u1 from the exponent and the atanh pass
    always_comb begin
        lnx  = $signed({4'd0, 36'(e_reg) * 36'(gng_pkg::LN2_Q30)}) + (z_i[39:0] <<< 1);
        negl = $signed(FULL_LN) - lnx;
    end

    // rotated pair from the unit and magnitudes of the quadrant-corrected pair
    always_comb begin
        c_q    = x_i[32:0];
        s_q    = y_i[32:0];
        cs_abs = cs_reg[32] ? 33'(-cs_reg) : 33'(cs_reg);
        sn_abs = sn_reg[32] ? 33'(-sn_reg) : 33'(sn_reg);
    end

    // shared multiplier, registered product
    always_comb begin
        unique case (state_reg)
            ST_V_MUL: begin
                mul_a = l2_reg;
                mul_b = {15'd0, variance};
            end
            ST_SQ_END: begin
                mul_a = {6'd0, ph_reg[29:0]};
                mul_b = gng_pkg::HALFPI_Q30;
            end
            ST_C_MUL: begin
                mul_a = {9'd0, r_reg};
                mul_b = cs_abs[30:0];
            end
            ST_S_MUL, ST_DONE: begin
                mul_a = {9'd0, r_reg};
                mul_b = sn_abs[30:0];
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_full = {31'd0, mul_a} * {36'd0, mul_b};
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_full[gng_pkg::PW-1:0];
    end

    // sequencer
    always_comb begin
        state_next       = state_reg;
        k_next           = k_reg;
        spare_valid_next = spare_valid_reg;
        spare_next       = spare_reg;
        m_next           = m_reg;
        e_next           = e_reg;
        ph_next          = ph_reg;
        l2_next          = l2_reg;
        r_next           = r_reg;
        cs_next          = cs_reg;
        sn_next          = sn_reg;
        cos_next         = cos_reg;
        out_wr           = '0;
        ctl              = '0;
        ctl.mode         = gng_pkg::MODE_HYP;
        ctl.k            = k_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    if (spare_valid_reg) begin
                        out_wr.valid     = 1'b1;
                        out_wr.sample    = spare_reg;
                        out_wr.spare     = 1'b1;
                        spare_valid_next = 1'b0;
                    end else begin
                        m_next     = {30'd0, xa} << 30;
                        e_next     = '0;
                        ph_next    = ({16'd0, uniform_b} & MASK_W[31:0]) << PH_SH;
                        state_next = ST_NORM;
                    end
                end
            end
            ST_NORM: begin
                if (|m_reg[62:31]) begin
                    m_next = m_reg >> 1;
                    e_next = e_reg + 6'd1;
                end else begin
                    ctl.load   = 1'b1;
                    ctl.x0     = $signed({27'd0, m_reg[30:0]}) + $signed({27'd0, gng_pkg::ONE_Q30});
                    ctl.y0     = $signed({27'd0, m_reg[30:0]}) - $signed({27'd0, gng_pkg::ONE_Q30});
                    ctl.z0     = '0;
                    k_next     = '0;
                    state_next = ST_LN_RUN;
                end
            end
            ST_LN_RUN: begin
                ctl.step = 1'b1;
                k_next   = k_reg + 5'd1;
                if (k_reg == gng_pkg::LN_LAST) begin
                    state_next = ST_LN_END;
                end
            end
            ST_LN_END: begin
                l2_next    = negl[39] ? 36'd0 : {negl[34:0], 1'b0};
                state_next = ST_V_MUL;
            end
            ST_V_MUL: begin
                state_next = ST_SQ_LOAD;
            end
            ST_SQ_LOAD: begin
                ctl.load   = 1'b1;
                ctl.mode   = gng_pkg::MODE_SQRT;
                ctl.x0     = '0;
                ctl.y0     = '0;
                ctl.z0     = $signed({4'd0, prod_reg[51:0], 2'b00});
                k_next     = '0;
                state_next = ST_SQ_RUN;
            end
            ST_SQ_RUN: begin
                ctl.step = 1'b1;
                ctl.mode = gng_pkg::MODE_SQRT;
                k_next   = k_reg + 5'd1;
                if (k_reg == gng_pkg::SQ_LAST) begin
                    state_next = ST_SQ_END;
                end
            end
            ST_SQ_END: begin
                r_next     = y_i[gng_pkg::RW-1:0];
                state_next = ST_SC_LOAD;
            end
            ST_SC_LOAD: begin
                ctl.load   = 1'b1;
                ctl.mode   = gng_pkg::MODE_CIRC;
                ctl.x0     = $signed({28'd0, gng_pkg::INVK_Q30});
                ctl.y0     = '0;
                ctl.z0     = $signed({27'd0, prod_reg[60:30]});
                k_next     = '0;
                state_next = ST_SC_RUN;
            end
            ST_SC_RUN: begin
                ctl.step = 1'b1;
                ctl.mode = gng_pkg::MODE_CIRC;
                k_next   = k_reg + 5'd1;
                if (k_reg == gng_pkg::SC_LAST) begin
                    state_next = ST_SC_END;
                end
            end
            ST_SC_END: begin
                // quadrant of the angle word
                unique case (ph_reg[31:30])
                    2'd0: begin
                        cs_next = c_q;
                        sn_next = s_q;
                    end
                    2'd1: begin
                        cs_next = -s_q;
                        sn_next = c_q;
                    end
                    2'd2: begin
                        cs_next = -c_q;
                        sn_next = -s_q;
                    end
                    default: begin
                        cs_next = s_q;
                        sn_next = -c_q;
                    end
                endcase
                state_next = ST_C_MUL;
            end
            ST_C_MUL: begin
                state_next = ST_S_MUL;
            end
            ST_S_MUL: begin
                cos_next   = gng_pkg::to_q88(prod_reg, cs_reg[32]);
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (slot_free) begin
                    out_wr.valid     = 1'b1;
                    out_wr.sample    = cos_reg;
                    out_wr.spare     = 1'b0;
                    spare_next       = gng_pkg::to_q88(prod_reg, sn_reg[32]);
                    spare_valid_next = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            k_reg           <= '0;
            spare_valid_reg <= 1'b0;
            spare_reg       <= '0;
        end else begin
            state_reg       <= state_next;
            k_reg           <= k_next;
            spare_valid_reg <= spare_valid_next;
            spare_reg       <= spare_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_reg   <= m_next;
        e_reg   <= e_next;
        ph_reg  <= ph_next;
        l2_reg  <= l2_next;
        r_reg   <= r_next;
        cs_reg  <= cs_next;
        sn_reg  <= sn_next;
        cos_reg <= cos_next;
    end

    // no new transaction while a pair is being formed
    a_busy_no_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !in_ready)
        else $error("input ready while pair in progress");

    // a pair is only formed with no spare held
    a_busy_no_spare: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !spare_valid_reg)
        else $error("spare held while forming a pair");

    // a held spare answers the next request at once
    a_spare_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_accept && spare_valid_reg) |-> (out_wr.valid && out_wr.spare))
        else $error("spare not returned");

    // every cosine result leaves a spare behind
    a_pair_spare: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_wr.valid && !out_wr.spare) |=> spare_valid_reg)
        else $error("spare not stored after pair");

endmodule

// ===== dv/tb_gaussian_noise_generator.sv =====
`timescale 1ns / 1ps

module tb_gaussian_noise_generator;

    localparam int UBITS     = 16;
    localparam int TOL       = 2;
    localparam int N_RANDOM  = 500;
    localparam int CYC_LIMIT = 400000;
    localparam longint Q1    = 64'd1073741824;
    localparam longint LN2Q  = 64'd744261118;
    localparam longint HPIQ  = 64'd1686629713;

    typedef struct {
        logic [15:0] sample;
        logic        spare;
    } noise_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data = '0;

    gaussian_noise_generator #(.UNIFORM_BITS(UBITS)) u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    // predictor state
    logic [15:0] var_q88;
    logic        spare_held;
    logic [15:0] spare_val;

    logic [31:0] word_queue[$];
    noise_t      sample_queue[$];
    int          send_idle_pct, recv_stall_pct;
    int          err_count, got_count, spare_count;
    longint      cycles;

    initial begin
        forever #1 aclk = ~aclk;
    end

    // natural log in Q30 by atanh series after normalising to [1,2)
    function automatic longint unsigned log_q30(input longint unsigned x);
        longint unsigned t, m, z, z2, acc, p;
        int e;
        e = 0;
        t = x;
        while (t > 1) begin
            t >>= 1;
            e++;
        end
        m = (x << 31) >> e;
        z = ((m - (64'd1 << 31)) << 30) / (m + (64'd1 << 31));
        z2 = (z * z) >> 30;
        acc = z;
        p = z;
        for (int k = 1; k <= 14; k++) begin
            p = (p * z2) >> 30;
            acc += p / (2 * k + 1);
        end
        return e * LN2Q + 2 * acc;
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    // radius Q20 times trig Q30 to rounded, saturated Q8.8
    function automatic logic [15:0] scale_q88(input longint r, input longint t);
        longint unsigned mag, v;
        mag = longint'(r) * (t < 0 ? -t : t);
        v = (mag + (64'd1 << 41)) >> 42;
        if (t < 0) begin
            if (v > 32768) v = 32768;
            return 16'(17'h10000 - v);
        end
        if (v > 32767) v = 32767;
        return 16'(v);
    endfunction

    // one request through the box-muller model
    function automatic noise_t predict_noise(input logic [31:0] words);
        noise_t res;
        longint unsigned x, wb, lx, fullv, neg_log, ph, f;
        longint r, ang, x2, ts, tc, ss, cc, cs, sn;
        int q;
        if (spare_held) begin
            spare_held = 1'b0;
            res.sample = spare_val;
            res.spare = 1'b1;
            return res;
        end
        x = longint'(words[15:0]) + 1;
        wb = words[31:16];
        fullv = UBITS * LN2Q;
        lx = log_q30(x);
        neg_log = (fullv > lx) ? fullv - lx : 0;
        r = int_sqrt(longint'(var_q88) * 2 * neg_log * 4);
        ph = wb << (32 - UBITS);
        q = int'((ph >> 30) & 3);
        f = ph & ((64'd1 << 30) - 1);
        ang = (f * HPIQ) >> 30;
        x2 = (ang * ang) / Q1;
        ts = ang; tc = Q1; ss = ang; cc = Q1;
        for (longint n = 1; n <= 9; n++) begin
            ts = (ts * x2) / Q1 / ((2 * n) * (2 * n + 1));
            tc = (tc * x2) / Q1 / ((2 * n - 1) * (2 * n));
            if (n & 1) begin
                ss -= ts; cc -= tc;
            end else begin
                ss += ts; cc += tc;
            end
        end
        case (q)
            0: begin cs = cc;  sn = ss;  end
            1: begin cs = -ss; sn = cc;  end
            2: begin cs = -cc; sn = -ss; end
            default: begin cs = ss; sn = -cc; end
        endcase
        spare_val = scale_q88(r, sn);
        spare_held = 1'b1;
        res.sample = scale_q88(r, cs);
        res.spare = 1'b0;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d (result %0d)", what, got, want, got_count);
        err_count++;
    endtask

    // driver: offers queued request words, predicts on each accepted transaction
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                sample_queue.push_back(predict_noise(s_tdata));
                void'(word_queue.pop_front());
            end
            if ((!s_tvalid || s_tready) || !s_tvalid) begin
                if (s_tvalid && !s_tready) begin
                    // hold the offered transaction
                end else if (word_queue.size() != 0
                             && $urandom_range(99) >= send_idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata <= word_queue[0];
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks each accepted result against the oldest expectation
    always @(posedge aclk) begin
        noise_t want;
        int diff;
        cycles++;
        if (aresetn) begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
            if (m_tvalid && m_tready) begin
                if (sample_queue.size() == 0) begin
                    report_mismatch("unexpected transaction", int'($signed(m_tdata)), 0);
                end else begin
                    want = sample_queue.pop_front();
                    diff = int'($signed(m_tdata)) - int'($signed(want.sample));
                    if (diff > TOL || diff < -TOL)
                        report_mismatch("sample", int'($signed(m_tdata)),
                                        int'($signed(want.sample)));
                    if (m_tuser !== want.spare)
                        report_mismatch("from_spare", int'(m_tuser), int'(want.spare));
                    if (want.spare) spare_count++;
                end
                got_count++;
            end
        end
        if (cycles > CYC_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("tb_gaussian_noise_generator: errors");
            $finish;
        end
    end

    task automatic drain_and_idle();
        while (word_queue.size() != 0 || s_tvalid || sample_queue.size() != 0)
            @(posedge aclk);
        repeat (150) @(posedge aclk);
    endtask

    task automatic write_variance(input logic [15:0] v);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do @(posedge aclk); while (!cfg_ready);
        var_q88 = v;
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] rand_word();
        case ($urandom_range(9))
            0: return 16'hFFFF;
            1: return 16'h0000;
            2: return 16'(1 << $urandom_range(15));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic push_random(input int n);
        for (int i = 0; i < n; i++)
            word_queue.push_back({rand_word(), rand_word()});
    endtask

    initial begin
        logic [15:0] var_set[6];
        cycles = 0;
        err_count = 0;
        got_count = 0;
        spare_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        var_q88 = 16'd256;
        spare_held = 1'b0;
        spare_val = '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: extremes of both words, each quadrant, spare drop, reset variance
        word_queue.push_back({16'h0000, 16'h0000});
        word_queue.push_back({16'hFFFF, 16'hFFFF});
        word_queue.push_back({16'h0000, 16'hFFFF});
        word_queue.push_back({16'hAAAA, 16'h5555});
        word_queue.push_back({16'h4000, 16'h0000});
        word_queue.push_back({16'h1234, 16'h0001});
        word_queue.push_back({16'h8000, 16'h0000});
        word_queue.push_back({16'h0000, 16'h0000});
        word_queue.push_back({16'hC000, 16'h8000});
        word_queue.push_back({16'h5555, 16'hAAAA});
        word_queue.push_back({16'hFFFF, 16'h7FFF});
        word_queue.push_back({16'h0000, 16'h0000});
        drain_and_idle();

        write_variance(16'hFFFF);
        word_queue.push_back({16'h0000, 16'h0000});
        word_queue.push_back({16'h0000, 16'h0000});
        word_queue.push_back({16'h4000, 16'h0000});
        word_queue.push_back({16'h0000, 16'h0000});
        drain_and_idle();
        write_variance(16'h0000);
        word_queue.push_back({16'h2000, 16'h0000});
        word_queue.push_back({16'h0000, 16'h0000});
        drain_and_idle();

        // random phases over variance settings and idling patterns
        var_set = '{16'd256, 16'hFFFF, 16'd1, 16'h0000, 16'd4096, 16'h8000};
        for (int ph = 0; ph < 6; ph++) begin
            write_variance(ph < 4 ? var_set[ph] : 16'($urandom));
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
                default: begin send_idle_pct = 6; recv_stall_pct = 6; end
            endcase
            push_random(N_RANDOM / 6);
            drain_and_idle();
        end

        $display("covered %0d results (%0d spare halves) over six variance settings",
                 got_count, spare_count);
        if (err_count == 0) begin
            $display("tb_gaussian_noise_generator: clean");
        end else begin
            $display("tb_gaussian_noise_generator: errors");
        end
        $finish;
    end

endmodule
